// ----- rtl/core/pwrfe_pkg.sv -----
// shared types and register map for the pulse width remote frame encoder
package pwrfe_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] command;
    } pwrfe_in_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } pwrfe_out_t;

    // request function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned PADDR_W   = 5;

    localparam logic [REG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_TICKS     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LONG_TICKS      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_HIGH_TICKS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_LOW_TICKS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAP_TICKS       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_COUNT    = 3'd6;

    localparam logic [31:0] RST_DEVICE_ADDRESS  = 32'h0101_0101;
    localparam logic [15:0] RST_SHORT_TICKS     = 16'd360;
    localparam logic [15:0] RST_LONG_TICKS      = 16'd720;
    localparam logic [15:0] RST_SYNC_HIGH_TICKS = 16'd4800;
    localparam logic [15:0] RST_SYNC_LOW_TICKS  = 16'd1500;
    localparam logic [15:0] RST_GAP_TICKS       = 16'd50000;
    localparam logic [3:0]  RST_REPEAT_COUNT    = 4'd5;

endpackage

// ----- rtl/core/pulse_width_remote_frame_encoder_top.sv -----
// top level of the pulse width remote frame encoder: registers, frame sequencer, result stage
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_data  (func, command)
//   m_        out        m_valid / m_ready   m_data  (line_level, busy_res, frame_done)
//   apb       in/out     psel / penable      paddr, pwdata, prdata
//
// one request is taken per clock while s_ready is high; the sequencer state and the result register
// are both updated in the cycle the request is accepted, so the result appears
// on m_ the next cycle. a new request is taken in the same cycle the previous
// result leaves. s_ready is low only while a result is held and m_ready is low.
// reset clears the sequencer to idle and loads register defaults.
module pulse_width_remote_frame_encoder_top #(
    parameter int unsigned ADDRESS_BITS = 32,
    parameter int unsigned COMMAND_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  pwrfe_pkg::pwrfe_in_t        s_data,

    output logic                        m_valid,
    input  logic                        m_ready,
    output pwrfe_pkg::pwrfe_out_t       m_data,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwrfe_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pwrfe_pkg::*;

    localparam int unsigned TOTAL_BITS = ADDRESS_BITS + COMMAND_BITS;
    localparam int unsigned BP_W       = $clog2(TOTAL_BITS);

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_SYNC_HIGH = 6'b000010,
        PH_SYNC_LOW  = 6'b000100,
        PH_BIT_HIGH  = 6'b001000,
        PH_BIT_LOW   = 6'b010000,
        PH_GAP       = 6'b100000
    } phase_t;

    // configuration registers
    logic [31:0] device_address_reg;
    logic [15:0] short_ticks_reg;
    logic [15:0] long_ticks_reg;
    logic [15:0] sync_high_ticks_reg;
    logic [15:0] sync_low_ticks_reg;
    logic [15:0] gap_ticks_reg;
    logic [3:0]  repeat_count_reg;

    // sequencer state
    phase_t                phase_reg, phase_next;
    logic [BP_W-1:0]       bit_pos_reg, bit_pos_next;
    logic [15:0]           tick_reg, tick_next;
    logic [TOTAL_BITS-1:0] shift_reg, shift_next;
    logic [3:0]            repeats_reg, repeats_next;

    logic       m_valid_reg, m_valid_next;
    pwrfe_out_t m_data_reg;
    pwrfe_out_t result;

    logic                 s_fire;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [BP_W-1:0]      bit_idx;
    logic                 cur_bit;
    logic                 phase_high;
    logic [15:0]          phase_len;
    logic [15:0]          tick_inc;
    logic                 tick_end;
    logic [15:0]          cmd_wide;
    logic [3:0]           repeats_dec;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg  <= RST_DEVICE_ADDRESS;
            short_ticks_reg     <= RST_SHORT_TICKS;
            long_ticks_reg      <= RST_LONG_TICKS;
            sync_high_ticks_reg <= RST_SYNC_HIGH_TICKS;
            sync_low_ticks_reg  <= RST_SYNC_LOW_TICKS;
            gap_ticks_reg       <= RST_GAP_TICKS;
            repeat_count_reg    <= RST_REPEAT_COUNT;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_DEVICE_ADDRESS:  device_address_reg  <= pwdata;
                REG_SHORT_TICKS:     short_ticks_reg     <= pwdata[15:0];
                REG_LONG_TICKS:      long_ticks_reg      <= pwdata[15:0];
                REG_SYNC_HIGH_TICKS: sync_high_ticks_reg <= pwdata[15:0];
                REG_SYNC_LOW_TICKS:  sync_low_ticks_reg  <= pwdata[15:0];
                REG_GAP_TICKS:       gap_ticks_reg       <= pwdata[15:0];
                REG_REPEAT_COUNT:    repeat_count_reg    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DEVICE_ADDRESS:  prdata = device_address_reg;
            REG_SHORT_TICKS:     prdata = {16'd0, short_ticks_reg};
            REG_LONG_TICKS:      prdata = {16'd0, long_ticks_reg};
            REG_SYNC_HIGH_TICKS: prdata = {16'd0, sync_high_ticks_reg};
            REG_SYNC_LOW_TICKS:  prdata = {16'd0, sync_low_ticks_reg};
            REG_GAP_TICKS:       prdata = {16'd0, gap_ticks_reg};
            REG_REPEAT_COUNT:    prdata = {28'd0, repeat_count_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign s_ready = ~m_valid_reg | m_ready;
    assign s_fire  = s_valid & s_ready;

    // frame is sent msb first, bit_pos counts from the top
    assign bit_idx    = BP_W'(TOTAL_BITS - 1) - bit_pos_reg;
    assign cur_bit    = shift_reg[bit_idx];
    assign phase_high = (phase_reg == PH_SYNC_HIGH) || (phase_reg == PH_BIT_HIGH);
    assign tick_inc   = tick_reg + 16'd1;
    assign cmd_wide   = {8'd0, s_data.command};
    assign repeats_dec = repeats_reg - 4'd1;

    always_comb begin
        unique case (phase_reg)
            PH_SYNC_HIGH: phase_len = sync_high_ticks_reg;
            PH_SYNC_LOW:  phase_len = sync_low_ticks_reg;
            PH_BIT_HIGH:  phase_len = cur_bit ? long_ticks_reg : short_ticks_reg;
            PH_BIT_LOW:   phase_len = cur_bit ? short_ticks_reg : long_ticks_reg;
            PH_GAP:       phase_len = gap_ticks_reg;
            default:      phase_len = 16'd1;
        endcase
    end

    // a zero length still ends after one tick; counter wrap also ends the phase
    assign tick_end = (tick_inc >= phase_len) || (tick_inc == 16'd0);

    always_comb begin
        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        repeats_next = repeats_reg;
        result.line_level = 1'b0;
        result.frame_done = 1'b0;

        if (s_data.func == FUNC_START) begin
            if (phase_reg == PH_IDLE) begin
                shift_next   = {device_address_reg[ADDRESS_BITS-1:0],
                                cmd_wide[COMMAND_BITS-1:0]};
                repeats_next = (repeat_count_reg == 4'd0) ? 4'd1 : repeat_count_reg;
                bit_pos_next = '0;
                tick_next    = 16'd0;
                phase_next   = PH_SYNC_HIGH;
                result.line_level = 1'b1;
            end else begin
                result.line_level = phase_high;
            end
        end else if (phase_reg != PH_IDLE) begin
            result.line_level = phase_high;
            tick_next = tick_inc;
            if (tick_end) begin
                tick_next = 16'd0;
                unique case (phase_reg)
                    PH_SYNC_HIGH: phase_next = PH_SYNC_LOW;
                    PH_SYNC_LOW: begin
                        phase_next   = PH_BIT_HIGH;
                        bit_pos_next = '0;
                    end
                    PH_BIT_HIGH: phase_next = PH_BIT_LOW;
                    PH_BIT_LOW: begin
                        if (bit_pos_reg != BP_W'(TOTAL_BITS - 1)) begin
                            bit_pos_next = bit_pos_reg + BP_W'(1);
                            phase_next   = PH_BIT_HIGH;
                        end else begin
                            bit_pos_next = '0;
                            repeats_next = repeats_dec;
                            if (repeats_dec == 4'd0) begin
                                phase_next        = PH_IDLE;
                                result.frame_done = 1'b1;
                            end else if (gap_ticks_reg == 16'd0) begin
                                phase_next = PH_SYNC_HIGH;
                            end else begin
                                phase_next = PH_GAP;
                            end
                        end
                    end
                    PH_GAP:  phase_next = PH_SYNC_HIGH;
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        result.busy_res = (phase_next != PH_IDLE);
    end

    assign m_valid_next = s_fire | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            bit_pos_reg <= '0;
            tick_reg    <= 16'd0;
            shift_reg   <= '0;
            repeats_reg <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                phase_reg   <= phase_next;
                bit_pos_reg <= bit_pos_next;
                tick_reg    <= tick_next;
                shift_reg   <= shift_next;
                repeats_reg <= repeats_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- bench/pwrfe_frame_checker.sv -----
`timescale 1ns / 1ps
// frame checker: predicts the encoder line for every request and compares the results
module pwrfe_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  pwrfe_pkg::pwrfe_in_t            s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  pwrfe_pkg::pwrfe_out_t           m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pwrfe_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending,
    output int                              frames_done
);
    import pwrfe_pkg::*;

    localparam int unsigned ADDR_BITS  = 32;
    localparam int unsigned CMD_BITS   = 8;
    localparam int unsigned FRAME_BITS = ADDR_BITS + CMD_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SYNC_HIGH,
        SEQ_SYNC_LOW,
        SEQ_BIT_HIGH,
        SEQ_BIT_LOW,
        SEQ_GAP
    } seq_phase_e;

    // register copies
    logic [31:0] cfg_addr;
    logic [15:0] cfg_short;
    logic [15:0] cfg_long;
    logic [15:0] cfg_sync_hi;
    logic [15:0] cfg_sync_lo;
    logic [15:0] cfg_gap;
    logic [3:0]  cfg_repeat;

    // sequencer copy
    seq_phase_e             seq_phase;
    int unsigned            bit_pos;
    logic [15:0]            tick_cnt;
    logic [FRAME_BITS-1:0]  frame_bits;
    logic [3:0]             repeats_left;

    pwrfe_out_t line_results_due[$];

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic cur_frame_bit();
        int unsigned pos;
        pos = (bit_pos >= FRAME_BITS) ? FRAME_BITS - 1 : bit_pos;
        return frame_bits[FRAME_BITS-1-pos];
    endfunction

    function automatic logic stage_level();
        return (seq_phase == SEQ_SYNC_HIGH) || (seq_phase == SEQ_BIT_HIGH);
    endfunction

    function automatic logic [15:0] stage_ticks();
        case (seq_phase)
            SEQ_SYNC_HIGH: return at_least_one(cfg_sync_hi);
            SEQ_SYNC_LOW:  return at_least_one(cfg_sync_lo);
            SEQ_BIT_HIGH:  return at_least_one(cur_frame_bit() ? cfg_long : cfg_short);
            SEQ_BIT_LOW:   return at_least_one(cur_frame_bit() ? cfg_short : cfg_long);
            SEQ_GAP:       return at_least_one(cfg_gap);
            default:       return 16'd1;
        endcase
    endfunction

    task automatic next_stage(output logic last);
        last = 1'b0;
        tick_cnt = 16'd0;
        case (seq_phase)
            SEQ_SYNC_HIGH: seq_phase = SEQ_SYNC_LOW;
            SEQ_SYNC_LOW: begin
                seq_phase = SEQ_BIT_HIGH;
                bit_pos = 0;
            end
            SEQ_BIT_HIGH: seq_phase = SEQ_BIT_LOW;
            SEQ_BIT_LOW: begin
                if (bit_pos + 1 < FRAME_BITS) begin
                    bit_pos = bit_pos + 1;
                    seq_phase = SEQ_BIT_HIGH;
                end else begin
                    bit_pos = 0;
                    repeats_left = repeats_left - 4'd1;
                    if (repeats_left == 4'd0) begin
                        seq_phase = SEQ_IDLE;
                        last = 1'b1;
                    end else begin
                        seq_phase = (cfg_gap == 16'd0) ? SEQ_SYNC_HIGH : SEQ_GAP;
                    end
                end
            end
            SEQ_GAP: seq_phase = SEQ_SYNC_HIGH;
            default: seq_phase = SEQ_IDLE;
        endcase
    endtask

    task automatic advance_encoder(input pwrfe_in_t req, output pwrfe_out_t res);
        logic last;
        last = 1'b0;
        res = '0;
        if (req.func == FUNC_START) begin
            // a start while busy leaves everything alone
            if (seq_phase == SEQ_IDLE) begin
                frame_bits = {cfg_addr, req.command};
                repeats_left = (cfg_repeat == 4'd0) ? 4'd1 : cfg_repeat;
                bit_pos = 0;
                tick_cnt = 16'd0;
                seq_phase = SEQ_SYNC_HIGH;
            end
            // the level is taken after the start, so an accepted start shows sync high
            res.line_level = (seq_phase == SEQ_IDLE) ? 1'b0 : stage_level();
        end else if (seq_phase != SEQ_IDLE) begin
            res.line_level = stage_level();
            tick_cnt = tick_cnt + 16'd1;
            // a shortened timing register can leave the count already past the end
            if (tick_cnt >= stage_ticks() || tick_cnt == 16'd0)
                next_stage(last);
        end
        res.busy_res = (seq_phase != SEQ_IDLE);
        res.frame_done = last;
    endtask

    always @(posedge aclk) begin : monitor
        pwrfe_out_t want;
        pwrfe_out_t res;
        if (!aresetn) begin
            cfg_addr     = RST_DEVICE_ADDRESS;
            cfg_short    = RST_SHORT_TICKS;
            cfg_long     = RST_LONG_TICKS;
            cfg_sync_hi  = RST_SYNC_HIGH_TICKS;
            cfg_sync_lo  = RST_SYNC_LOW_TICKS;
            cfg_gap      = RST_GAP_TICKS;
            cfg_repeat   = RST_REPEAT_COUNT;
            seq_phase    = SEQ_IDLE;
            bit_pos      = 0;
            tick_cnt     = 16'd0;
            frame_bits   = '0;
            repeats_left = 4'd0;
            line_results_due.delete();
            pending = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (line_results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no request waiting: line %b busy %b done %b",
                                 $time, m_data.line_level, m_data.busy_res, m_data.frame_done);
                end else begin
                    want = line_results_due.pop_front();
                    if (m_data.line_level !== want.line_level ||
                        m_data.busy_res !== want.busy_res ||
                        m_data.frame_done !== want.frame_done) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch line/busy/done expected %b%b%b got %b%b%b",
                                     $time, want.line_level, want.busy_res, want.frame_done,
                                     m_data.line_level, m_data.busy_res, m_data.frame_done);
                    end
                end
                if (m_data.frame_done === 1'b1)
                    frames_done++;
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[REG_IDX_W+1:2])
                    REG_DEVICE_ADDRESS:  cfg_addr    = pwdata;
                    REG_SHORT_TICKS:     cfg_short   = pwdata[15:0];
                    REG_LONG_TICKS:      cfg_long    = pwdata[15:0];
                    REG_SYNC_HIGH_TICKS: cfg_sync_hi = pwdata[15:0];
                    REG_SYNC_LOW_TICKS:  cfg_sync_lo = pwdata[15:0];
                    REG_GAP_TICKS:       cfg_gap     = pwdata[15:0];
                    REG_REPEAT_COUNT:    cfg_repeat  = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_encoder(s_data, res);
                line_results_due.push_back(res);
            end
            pending = line_results_due.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, request and register stimulus, watchdog and verdict
module tb_top;
    import pwrfe_pkg::*;

    localparam int RANDOM_ITEMS   = 330;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    pwrfe_in_t          s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    pwrfe_out_t         m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int pending;
    int frames_done;
    int items_sent = 0;
    int starts_sent = 0;
    int reg_writes = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    pulse_width_remote_frame_encoder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pwrfe_frame_checker frame_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .pending     (pending),
        .frames_done (frames_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(1, 2);
        if (r < 85) return $urandom_range(3, 6);
        if (r < 97) return $urandom_range(7, 15);
        return $urandom_range(25, 45);
    endfunction

    // pulse lengths stay tiny so whole frames fit in the run, zero included
    function automatic logic [31:0] pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 1);
        if (r < 85) return $urandom_range(2, 3);
        return $urandom_range(4, 6);
    endfunction

    function automatic logic [31:0] pick_reg_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_DEVICE_ADDRESS: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            end
            REG_GAP_TICKS:    return ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 5);
            REG_REPEAT_COUNT: return $urandom_range(0, 3);
            REG_UNMAPPED:     return $urandom;
            default:          return pick_ticks();
        endcase
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (!take_steady && $urandom_range(0, 99) < 30) begin
            m_ready = 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // valid stays high across back-to-back requests
    task automatic send_req(input logic f, input logic [7:0] cmd);
        int gap;
        gap = (send_steady || $urandom_range(0, 99) < 45) ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data.func = f;
        s_data.command = cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (f == FUNC_START) starts_sent++;
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        reg_writes++;
    endtask

    initial begin : stimulus
        int directed_items;
        int n;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // tick while idle
        send_req(FUNC_TICK, 8'hFF);
        wait_results();

        // every register at its top value, upper bits of narrow registers dropped
        write_reg(REG_DEVICE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(REG_SHORT_TICKS, 32'hFFFF_FFFF);
        write_reg(REG_LONG_TICKS, 32'h0000_FFFF);
        write_reg(REG_SYNC_HIGH_TICKS, 32'h0000_FFFF);
        write_reg(REG_SYNC_LOW_TICKS, 32'h0000_FFFF);
        write_reg(REG_GAP_TICKS, 32'h0000_FFFF);
        write_reg(REG_REPEAT_COUNT, 32'h0000_000F);
        send_req(FUNC_TICK, 8'h00);
        wait_results();

        // zero repeat count runs one frame; second start is ignored while busy
        write_reg(REG_REPEAT_COUNT, 32'd0);
        send_req(FUNC_START, 8'hFF);
        send_req(FUNC_START, 8'h00);
        repeat (3) send_req(FUNC_TICK, 8'($urandom));
        wait_results();

        // shrink timing in the middle of sync high, zero lengths last one tick
        write_reg(REG_SHORT_TICKS, 32'd0);
        write_reg(REG_LONG_TICKS, 32'd0);
        write_reg(REG_SYNC_HIGH_TICKS, 32'd0);
        write_reg(REG_SYNC_LOW_TICKS, 32'd0);
        write_reg(REG_GAP_TICKS, 32'd0);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        repeat (90) send_req(FUNC_TICK, 8'($urandom));
        wait_results();

        // two frames back to back with no gap
        write_reg(REG_DEVICE_ADDRESS, 32'h8000_0000);
        write_reg(REG_LONG_TICKS, 32'd1);
        write_reg(REG_REPEAT_COUNT, 32'd2);
        send_req(FUNC_START, 8'h80);
        repeat (170) send_req(FUNC_TICK, 8'($urandom));
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS) begin
            wait_results();
            send_steady = 1'b0;
            take_steady = 1'b0;
            // registers change between bursts, often in the middle of a frame
            for (int r = 0; r <= REG_UNMAPPED; r++) begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_IDX_W'(r), pick_reg_value(REG_IDX_W'(r)));
            end
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(30, 160);
            for (int k = 0; k < n && items_sent < directed_items + RANDOM_ITEMS; k++) begin
                if ((k == 0 && $urandom_range(0, 9) < 7) || $urandom_range(0, 99) < 3)
                    send_req(FUNC_START, 8'($urandom));
                else
                    send_req(FUNC_TICK, 8'($urandom));
            end
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("covered %0d requests with %0d starts and %0d register writes",
                 items_sent, starts_sent, reg_writes);
        $display("%0d frames finished, %0d failures", frames_done, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pwrfe_pkg.sv
rtl/core/pulse_width_remote_frame_encoder_top.sv
bench/pwrfe_frame_checker.sv
bench/tb_top.sv
